// ===== hdl/oversampled_uart_tx_rx_defines.svh =====
// Assertion macros shared by the checker.
`ifndef OVERSAMPLED_UART_TX_RX_DEFINES_SVH
`define OVERSAMPLED_UART_TX_RX_DEFINES_SVH

// antecedent holds -> consequent holds on the same edge
`define OUART_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent holds -> consequent holds on the next edge
`define OUART_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/ouart_pkg.sv =====
package ouart_pkg;

  localparam int OVERSAMPLE = 4;
  localparam int SUB_W = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;
  localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(OVERSAMPLE - 1);

  localparam logic [3:0] TX_FIRST_DATA = 4'd9;
  localparam logic [3:0] RX_STOP = 4'd10;

  typedef struct packed {
    logic       rx_line;
    logic       tx_write;
    logic [7:0] tx_data;
  } in_word_t;

  typedef struct packed {
    logic       tx_line;
    logic       tx_buffer_empty;
    logic       rx_valid;
    logic [7:0] rx_data;
  } out_word_t;

  // per-tick control handed to the tx and rx units
  typedef struct packed {
    logic             en;        // a tick is being processed this cycle
    logic             bit_tick;  // subtick wrapped to zero on this tick
    logic [SUB_W-1:0] sub;       // subtick value after this tick
  } tick_ctrl_t;

endpackage

// ===== hdl/ouart_tx.sv =====
module ouart_tx (
  input  logic                   clk,
  input  logic                   rst,
  input  ouart_pkg::tick_ctrl_t  ctrl,
  input  logic                   tx_write,
  input  logic [7:0]             tx_data,
  output logic                   tx_pin_next,
  output logic                   tx_empty_next
);
  import ouart_pkg::*;

  logic [3:0] tx_count, tx_count_next;
  logic [7:0] tx_hold;
  logic       tx_empty;
  logic [7:0] tx_shift, tx_shift_next;
  logic       tx_pin;

  logic [7:0] hold_w;
  logic       empty_w;

  always_comb begin
    // buffer write lands before the tick
    hold_w        = tx_write ? tx_data : tx_hold;
    empty_w       = tx_write ? 1'b0 : tx_empty;
    tx_count_next = tx_count;
    tx_shift_next = tx_shift;
    tx_pin_next   = tx_pin;
    tx_empty_next = empty_w;
    if (ctrl.bit_tick) begin
      if (tx_count == 4'd0) begin
        if (!empty_w) begin
          tx_shift_next = hold_w;
          tx_empty_next = 1'b1;
          tx_count_next = TX_FIRST_DATA;
          tx_pin_next   = 1'b0;
        end
      end else if (tx_count == 4'd1) begin
        tx_count_next = 4'd0;
        tx_pin_next   = 1'b1;
      end else begin
        tx_pin_next   = tx_shift[0];
        tx_shift_next = {1'b0, tx_shift[7:1]};
        tx_count_next = tx_count - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_count <= 4'd0;
      tx_empty <= 1'b1;
      tx_pin   <= 1'b1;
    end else if (ctrl.en) begin
      tx_count <= tx_count_next;
      tx_empty <= tx_empty_next;
      tx_pin   <= tx_pin_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      tx_hold  <= hold_w;
      tx_shift <= tx_shift_next;
    end
  end

endmodule

// ===== hdl/ouart_rx.sv =====
module ouart_rx (
  input  logic                   clk,
  input  logic                   rst,
  input  ouart_pkg::tick_ctrl_t  ctrl,
  input  logic                   rx_line,
  output logic                   rx_valid_next,
  output logic [7:0]             rx_last_next
);
  import ouart_pkg::*;

  logic [3:0]       rx_count, rx_count_next;
  logic [SUB_W-1:0] rx_phase, rx_phase_next;
  logic [7:0]       rx_shift, rx_shift_next;
  logic [7:0]       rx_last;

  always_comb begin
    rx_count_next = rx_count;
    rx_phase_next = rx_phase;
    rx_shift_next = rx_shift;
    rx_last_next  = rx_last;
    rx_valid_next = 1'b0;
    if (rx_count == 4'd0) begin
      if (!rx_line) rx_count_next = 4'd1;
    end else if (rx_count == 4'd1) begin
      // second low tick confirms the start bit and fixes the sample phase
      if (!rx_line) begin
        rx_phase_next = ctrl.sub;
        rx_count_next = 4'd2;
      end else begin
        rx_count_next = 4'd0;
      end
    end else if (ctrl.sub == rx_phase) begin
      if (rx_count >= RX_STOP) begin
        if (rx_line) begin
          rx_last_next  = rx_shift;
          rx_valid_next = 1'b1;
        end
        rx_count_next = 4'd0;
      end else begin
        rx_shift_next = {rx_line, rx_shift[7:1]};
        rx_count_next = rx_count + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_count <= 4'd0;
      rx_phase <= '0;
      rx_shift <= 8'd0;
      rx_last  <= 8'd0;
    end else if (ctrl.en) begin
      rx_count <= rx_count_next;
      rx_phase <= rx_phase_next;
      rx_shift <= rx_shift_next;
      rx_last  <= rx_last_next;
    end
  end

endmodule

// ===== hdl/oversampled_uart_tx_rx.sv =====
// 8N1 UART at four ticks per bit. Each input word is one oversampling tick
// (receive pin level plus an optional transmit byte write) and yields exactly
// one output word with the transmit pin, buffer-empty flag, a one-tick receive
// strobe and the last good byte. A word is registered on entry; the tx and rx
// state is updated as the word moves from the entry register to the output
// register, which then offers the result. One word per clock is sustained
// while out_ready does not stall the output register. in_ready is high while
// the entry register is empty or the output register is empty or being taken.
module oversampled_uart_tx_rx (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ouart_pkg::in_word_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ouart_pkg::out_word_t  out_data
);
  import ouart_pkg::*;

  logic             s1_valid;
  in_word_t         s1_word;
  logic             adv;
  logic [SUB_W-1:0] subtick, subtick_next;
  tick_ctrl_t       ctrl;
  logic             tx_pin_next, tx_empty_next;
  logic             rx_valid_next;
  logic [7:0]       rx_last_next;

  assign adv      = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || adv;

  assign subtick_next  = (subtick == SUB_LAST) ? '0 : subtick + SUB_W'(1);
  assign ctrl.en       = adv;
  assign ctrl.bit_tick = adv && (subtick == SUB_LAST);
  assign ctrl.sub      = subtick_next;

  ouart_tx u_tx (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .tx_write      (s1_word.tx_write),
    .tx_data       (s1_word.tx_data),
    .tx_pin_next   (tx_pin_next),
    .tx_empty_next (tx_empty_next)
  );

  ouart_rx u_rx (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .rx_line       (s1_word.rx_line),
    .rx_valid_next (rx_valid_next),
    .rx_last_next  (rx_last_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      subtick   <= '0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (adv) begin
        out_valid <= 1'b1;
        subtick   <= subtick_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s1_word <= in_data;
    if (adv) begin
      out_data.tx_line         <= tx_pin_next;
      out_data.tx_buffer_empty <= tx_empty_next;
      out_data.rx_valid        <= rx_valid_next;
      out_data.rx_data         <= rx_last_next;
    end
  end

endmodule

// ===== hdl/ouart_checker.sv =====
`include "oversampled_uart_tx_rx_defines.svh"

module ouart_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input ouart_pkg::out_word_t  out_data
);
  import ouart_pkg::*;

  // a stalled result word holds
  `OUART_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // with nothing waiting at the output the input side must be open
  `OUART_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)

  // an accepted receive strobe is not followed by another strobe in the next result word
  `OUART_ASSERT_NEXT(a_rx_strobe_single, out_valid && out_ready && out_data.rx_valid, !(out_valid && out_data.rx_valid))

endmodule

bind oversampled_uart_tx_rx ouart_checker u_ouart_checker (.*);
